### src/ultrasonic_echo_ranger_core_defines.svh
// Assertion macros for the ranger core.
// UER_ASSERT_SAME: consequent checked in the same cycle as the antecedent.
// UER_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define UER_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ranger core check failed");
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ranger core check failed");
`else
`define UER_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define UER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/uer_pkg.sv
`default_nettype none
package uer_pkg;

  localparam int PERIOD_W = 20;
  localparam int CFG_W    = 20;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK  = 2'd0;
  localparam op_t OP_WRITE = 2'd1;
  localparam op_t OP_READ  = 2'd2;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_UNSET    = 2'd0;
  localparam mode_t MODE_ONESHOT  = 2'd1;
  localparam mode_t MODE_PERIODIC = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_STOPPED = 2'd2;
  localparam status_t ST_NOMODE  = 2'd3;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_MODE   = 1'b0;
  localparam cfg_idx_t CFG_PERIOD = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd100000;

  // decoded command for the trigger sequencer
  typedef struct packed {
    logic fire;
    logic set_run;
    logic clr_run;
  } seq_cmd_t;

  typedef struct packed {
    logic trigger;
    logic measuring;
    logic running;
  } seq_stat_t;

endpackage
`default_nettype wire

### src/ultrasonic_echo_ranger_core.sv
// Channel | Direction | Handshake         | Payload
// in_     | input     | in_valid/in_stall | in_operation, in_write_arg, in_echo_level
// out_    | output    | out_valid/out_stall | trigger, read result, fifo_count, measuring
// cfg_    | input     | cfg_we            | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_stall is low; each request passes
// through the input register, then the result register (a single pass of logic).
// The echo, FIFO and trigger state update as each request enters the result register.
// Reset is synchronous, active low; the FIFO contents are not cleared.
// With out_stall high the result holds and one more request is buffered,
// after which in_stall rises.
`default_nettype none
`include "ultrasonic_echo_ranger_core_defines.svh"
module ultrasonic_echo_ranger_core import uer_pkg::*; #(
  parameter int STORE_DEPTH   = 5,
  parameter int TRIGGER_TICKS = 10,
  parameter int WIDTH_BITS    = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire cfg_idx_t         cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_operation,
  input  wire logic [7:0]       in_write_arg,
  input  wire logic             in_echo_level,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_trigger_level,
  output logic                  out_read_valid,
  output logic [15:0]           out_read_data,
  output logic [1:0]            out_read_status,
  output logic [2:0]            out_fifo_count,
  output logic                  out_measuring
);

  localparam int CW = $clog2(STORE_DEPTH + 1);

  mode_t               mode_r;
  logic [PERIOD_W-1:0] period_r;

  logic      s1_valid_r;
  op_t       s1_op_r;
  logic [7:0] s1_arg_r;
  logic      s1_echo_r;
  logic      in_take, adv;

  logic                  push, empty_after_push;
  logic [WIDTH_BITS-1:0] push_val, rd_data;
  logic [CW-1:0]         count_nxt;
  logic                  clear, pop, running;
  seq_cmd_t              cmd;
  seq_stat_t             stat;
  status_t               status;

  logic      out_valid_r;
  logic      trig_r, rvalid_r, meas_r;
  status_t   status_r;
  logic [2:0] count_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_UNSET;
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode_r   <= mode_t'(cfg_wdata[1:0]);
        CFG_PERIOD: period_r <= cfg_wdata[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  // input register
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= in_operation;
      s1_arg_r  <= in_write_arg;
      s1_echo_r <= in_echo_level;
    end
  end

  uer_echo #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_echo (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .echo_level (s1_echo_r),
    .push       (push),
    .push_val   (push_val)
  );

  // command decode; echo push is already folded into empty_after_push
  always_comb begin
    cmd    = '0;
    clear  = 1'b0;
    pop    = 1'b0;
    status = ST_OK;
    case (s1_op_r)
      OP_WRITE: begin
        if (mode_r == MODE_ONESHOT) begin
          clear    = (s1_arg_r != 8'd0);
          cmd.fire = 1'b1;
        end else if (mode_r == MODE_PERIODIC) begin
          if (s1_arg_r == 8'd0) begin
            cmd.clr_run = 1'b1;
          end else if (s1_arg_r == 8'd1) begin
            cmd.set_run = 1'b1;
            cmd.fire    = 1'b1;
          end
        end
      end
      OP_READ: begin
        if (mode_r == MODE_ONESHOT || mode_r == MODE_PERIODIC) begin
          cmd.fire = (mode_r == MODE_ONESHOT);
          if (mode_r == MODE_PERIODIC && !running) begin
            status = ST_STOPPED;
          end else if (empty_after_push) begin
            status = ST_EMPTY;
          end else begin
            pop = 1'b1;
          end
        end else begin
          status = ST_NOMODE;
        end
      end
      default: ;
    endcase
  end

  uer_store #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (WIDTH_BITS)
  ) u_store (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .push             (push),
    .push_val         (push_val),
    .clear            (clear),
    .pop              (pop),
    .empty_after_push (empty_after_push),
    .count_nxt        (count_nxt),
    .rd_data_r        (rd_data)
  );

  uer_trig #(
    .TRIGGER_TICKS (TRIGGER_TICKS)
  ) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .mode    (mode_r),
    .period  (period_r),
    .cmd     (cmd),
    .stat    (stat),
    .running (running)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trig_r   <= stat.trigger;
      meas_r   <= stat.measuring;
      rvalid_r <= pop;
      status_r <= status;
      count_r  <= 3'(count_nxt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = trig_r;
  assign out_measuring     = meas_r;
  assign out_read_valid    = rvalid_r;
  assign out_read_status   = status_r;
  assign out_read_data     = 16'(rd_data);
  assign out_fifo_count    = count_r;

  `UER_ASSERT_SAME(a_pop_ok, clk, rst_n, out_valid && out_read_valid,
                   out_read_status == ST_OK)
  `UER_ASSERT_SAME(a_trig_in_seq, clk, rst_n, out_valid && out_trigger_level,
                   out_measuring)
  `UER_ASSERT_NEXT(a_buf_drains, clk, rst_n, adv && !in_take, !s1_valid_r)
  `UER_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && out_stall && !adv,
                   out_valid && $stable(out_fifo_count))

endmodule
`default_nettype wire

### src/uer_echo.sv
`default_nettype none
module uer_echo import uer_pkg::*; #(
  parameter int WIDTH_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  adv,
  input  wire logic                  echo_level,
  output logic                       push,
  output logic [WIDTH_BITS-1:0]      push_val
);

  logic                  in_echo_r, in_echo_nxt;
  logic [WIDTH_BITS-1:0] width_r, width_nxt;

  always_comb begin
    in_echo_nxt = in_echo_r;
    width_nxt   = width_r;
    push        = 1'b0;
    push_val    = width_r;
    if (echo_level) begin
      if (!in_echo_r) begin
        in_echo_nxt = 1'b1;
        width_nxt   = WIDTH_BITS'(1);
      end else if (width_r != '1) begin
        width_nxt = width_r + WIDTH_BITS'(1);
      end
    end else if (in_echo_r) begin
      push        = 1'b1;
      in_echo_nxt = 1'b0;
      width_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_echo_r <= 1'b0;
      width_r   <= '0;
    end else if (adv) begin
      in_echo_r <= in_echo_nxt;
      width_r   <= width_nxt;
    end
  end

endmodule
`default_nettype wire

### src/uer_store.sv
`default_nettype none
module uer_store import uer_pkg::*; #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 16,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_val,
  input  wire logic             clear,
  input  wire logic             pop,
  output logic                  empty_after_push,
  output logic [CW-1:0]         count_nxt,
  output logic [WIDTH-1:0]      rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  logic [PW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r;
  logic [PW-1:0] head_a, head_a_inc, slot;
  logic [CW-1:0] count_a;
  logic [PW:0]   slot_sum;
  logic          bypass;

  always_comb begin
    // push step: drop the oldest entry when full
    head_a  = head_r;
    count_a = count_r;
    if (push && (count_r == CW'(DEPTH))) begin
      head_a  = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
      count_a = CW'(DEPTH - 1);
    end
    slot_sum = (PW + 1)'(head_a) + (PW + 1)'(count_a);
    slot     = (slot_sum >= (PW + 1)'(DEPTH)) ? PW'(slot_sum - (PW + 1)'(DEPTH))
                                               : PW'(slot_sum);
    if (push) begin
      count_a = count_a + CW'(1);
    end
    empty_after_push = (count_a == '0);

    head_a_inc = (head_a == PW'(DEPTH - 1)) ? '0 : head_a + PW'(1);
    head_nxt   = head_a;
    count_nxt  = count_a;
    if (clear) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (pop) begin
      head_nxt  = head_a_inc;
      count_nxt = count_a - CW'(1);
    end
    bypass = push && (slot == head_a);
  end

  always_ff @(posedge clk) begin
    if (adv && push) begin
      mem[slot] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (!pop) begin
        rd_data_r <= '0;
      end else if (bypass) begin
        rd_data_r <= push_val;
      end else begin
        rd_data_r <= mem[head_a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (adv) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### src/uer_trig.sv
`default_nettype none
module uer_trig import uer_pkg::*; #(
  parameter int TRIGGER_TICKS = 10
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                adv,
  input  wire mode_t               mode,
  input  wire logic [PERIOD_W-1:0] period,
  input  wire seq_cmd_t            cmd,
  output seq_stat_t                stat,
  output logic                     running
);

  localparam int PCW = $clog2(TRIGGER_TICKS + 1);

  logic                busy_r, busy_nxt, busy_a;
  logic                run_r, run_nxt;
  logic [PCW-1:0]      pulse_r, pulse_nxt, pulse_a;
  logic [PERIOD_W-1:0] per_r, per_nxt, per_a, per_dec;
  logic                periodic_on;

  assign running = run_r;

  always_comb begin
    run_nxt = run_r;
    if (cmd.set_run) begin
      run_nxt = 1'b1;
    end else if (cmd.clr_run) begin
      run_nxt = 1'b0;
    end

    busy_a  = busy_r;
    pulse_a = pulse_r;
    per_a   = per_r;
    if (cmd.fire && !busy_r) begin
      busy_a  = 1'b1;
      pulse_a = PCW'(TRIGGER_TICKS);
      per_a   = '0;
    end

    stat.trigger   = busy_a && (pulse_a != '0);
    stat.measuring = busy_a;
    stat.running   = run_nxt;

    periodic_on = (mode == MODE_PERIODIC) && run_nxt;
    busy_nxt    = busy_a;
    pulse_nxt   = pulse_a;
    per_nxt     = per_a;
    per_dec     = (per_a != '0) ? per_a - PERIOD_W'(1) : '0;
    if (busy_a) begin
      if (pulse_a != '0) begin
        pulse_nxt = pulse_a - PCW'(1);
        if (pulse_a == PCW'(1)) begin
          if (periodic_on) begin
            per_nxt = (period == '0) ? PERIOD_W'(1) : period;
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end else begin
        per_nxt = per_dec;
        if (per_dec == '0) begin
          if (periodic_on) begin
            pulse_nxt = PCW'(TRIGGER_TICKS);
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      run_r   <= 1'b0;
      pulse_r <= '0;
      per_r   <= '0;
    end else if (adv) begin
      busy_r  <= busy_nxt;
      run_r   <= run_nxt;
      pulse_r <= pulse_nxt;
      per_r   <= per_nxt;
    end
  end

endmodule
`default_nettype wire
